// ===== design/text_console_writer_top_macros.svh =====
// Assertion macros used by the console writer back module (tcw_back).
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// The property must hold at every edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition implies another one in the next cycle.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tcw_pkg.sv =====
//------------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
//------------------------------------------------------------------------------
`default_nettype none
package tcw_pkg;
	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW = $clog2(CELLS);
	localparam int XW = $clog2(COLUMNS);
	localparam int YW = $clog2(ROWS);

	localparam logic [2:0] CMD_PUT_CUR = 3'd0;
	localparam logic [2:0] CMD_PUT_POS = 3'd1;
	localparam logic [2:0] CMD_MOVE = 3'd2;
	localparam logic [2:0] CMD_CLEAR = 3'd3;
	localparam logic [2:0] CMD_READ = 3'd4;

	localparam logic [7:0] NEWLINE = 8'd10;
	localparam logic [15:0] BLANK_CELL = 16'h0F20;

	// Classified operation handed from the front part to the back part.
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_NEWLINE = 3'd2;
	localparam logic [2:0] OP_MOVE = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;
	localparam logic [2:0] OP_READ = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic use_cursor;
		logic [CW-1:0] pos;
		logic [15:0] data;
		logic signed [11:0] delta;
	} tcw_op_t;
endpackage
`default_nettype wire

// ===== design/text_console_writer_top.sv =====
//------------------------------------------------------------------------------
// text_console_writer_top
// Text console engine over a COLUMNS x ROWS cell memory.
//------------------------------------------------------------------------------
// Channel | Direction | Handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// cfg     | input     | APB read and write, pready tied high
// In the back sequencer a put, move or no-op goes from IDLE to DONE, a read through READ.
// A scroll copies each cell up one row, in a read state and then a write state, then
// zeroes the last row. A clear writes a blank cell to every cell.
// Reset clears cursor and control; the cell memory is undefined until written.
// The front holds one command while the back is busy; in_stall rises then.
`default_nettype none
module text_console_writer_top import tcw_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] command,
	input wire logic [7:0] character,
	input wire logic [7:0] attribute,
	input wire logic [6:0] column,
	input wire logic [4:0] row,
	input wire logic signed [11:0] delta,
	output logic out_valid,
	input wire logic out_stall,
	output logic [10:0] cursor_cell,
	output logic scrolled,
	output logic [7:0] read_character,
	output logic [7:0] read_attribute,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [7:0] def_attr_q;
	logic op_valid;
	logic op_stall;
	tcw_op_t op;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {24'd0, def_attr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_attr_q <= 8'd15;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			def_attr_q <= pwdata[7:0];
		end
	end

	tcw_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .character, .attribute,
		.column, .row, .delta, .default_attribute(def_attr_q),
		.op_valid, .op, .op_stall
	);

	tcw_back u_back (
		.clk, .arst_n, .op_valid, .op, .op_stall, .out_valid, .out_stall,
		.cursor_cell, .scrolled, .read_character, .read_attribute
	);
endmodule
`default_nettype wire

// ===== design/tcw_front.sv =====
//------------------------------------------------------------------------------
// tcw_front
// Accepts commands, clamps positions and classifies them into operations.
//------------------------------------------------------------------------------
`default_nettype none
module tcw_front import tcw_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] command,
	input wire logic [7:0] character,
	input wire logic [7:0] attribute,
	input wire logic [6:0] column,
	input wire logic [4:0] row,
	input wire logic signed [11:0] delta,
	input wire logic [7:0] default_attribute,
	output logic op_valid,
	output tcw_op_t op,
	input wire logic op_stall
);
	tcw_op_t op_q;
	logic valid_q;
	tcw_op_t nx;
	logic [XW-1:0] cx;
	logic [YW-1:0] ry;
	logic [7:0] at;

	assign in_stall = valid_q && op_stall;
	assign op_valid = valid_q;
	assign op = op_q;

	always_comb begin
		cx = (column > 7'(COLUMNS - 1)) ? XW'(COLUMNS - 1) : column[XW-1:0];
		ry = (row > 5'(ROWS - 1)) ? YW'(ROWS - 1) : row[YW-1:0];
		at = (attribute == 8'd0) ? default_attribute : attribute;
		nx.op = OP_NONE;
		nx.use_cursor = (command == CMD_PUT_CUR);
		nx.pos = CW'(ry * COLUMNS) + CW'(cx);
		nx.data = {at, character};
		nx.delta = delta;
		case (command)
			CMD_PUT_CUR, CMD_PUT_POS: begin
				if (character == NEWLINE) nx.op = OP_NEWLINE;
				else if (character != 8'd0) nx.op = OP_WRITE;
			end
			CMD_MOVE: nx.op = OP_MOVE;
			CMD_CLEAR: nx.op = OP_CLEAR;
			CMD_READ: nx.op = OP_READ;
			default: nx.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) op_q <= nx;
	end
endmodule
`default_nettype wire

// ===== design/tcw_back.sv =====
//------------------------------------------------------------------------------
// tcw_back
// Executes operations on the cell memory and the cursor; scrolls and clears.
//------------------------------------------------------------------------------
`default_nettype none
module tcw_back import tcw_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic op_valid,
	input tcw_op_t op,
	output logic op_stall,
	output logic out_valid,
	input wire logic out_stall,
	output logic [10:0] cursor_cell,
	output logic scrolled,
	output logic [7:0] read_character,
	output logic [7:0] read_attribute
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_SCR_RD = 3'd2;
	localparam logic [2:0] ST_SCR_WR = 3'd3;
	localparam logic [2:0] ST_FILL = 3'd4;
	localparam logic [2:0] ST_CLEAR = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;
	localparam logic [14:0] DIV5_RECIP = 15'd205;

	logic [15:0] mem [CELLS];
	logic [15:0] rd_q;
	logic [2:0] state_q;
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] idx_q;
	logic out_valid_q;
	logic scr_q;
	logic [15:0] rdout_q;
	logic [CW-1:0] where;
	logic [6:0] where_hi;
	logic [14:0] row_prod;
	logic [4:0] where_row;
	logic [CW-1:0] rowbase;
	logic [CW-1:0] nl_where;
	logic signed [CW+1:0] moved;
	logic take;
	logic we;
	logic [CW-1:0] waddr;
	logic [15:0] wdata;
	logic [CW-1:0] raddr;

	assign take = op_valid && state_q == ST_IDLE && !out_valid_q;
	assign op_stall = !take;
	assign out_valid = out_valid_q;
	assign cursor_cell = 11'(cursor_q);
	assign scrolled = scr_q;
	assign read_character = rdout_q[7:0];
	assign read_attribute = rdout_q[15:8];

	always_comb begin
		where = op.use_cursor ? cursor_q : op.pos;
		// The row is the cell divided by 80: a shift by 4, then a divide by 5 done as
		// a multiply by 205/1024, which is exact for the 7-bit dividend range.
		where_hi = where[CW-1:4];
		row_prod = 15'(where_hi) * DIV5_RECIP;
		where_row = row_prod[14:10];
		rowbase = CW'(where_row * COLUMNS);
		nl_where = rowbase + CW'(COLUMNS - 1);
		moved = $signed({2'b00, cursor_q}) + (CW+2)'(op.delta);
		we = 1'b0;
		waddr = idx_q;
		wdata = rd_q;
		raddr = idx_q + CW'(COLUMNS);
		if (take && op.op == OP_WRITE) begin
			we = 1'b1;
			waddr = where;
			wdata = op.data;
		end else if (state_q == ST_SCR_WR) begin
			we = 1'b1;
		end else if (state_q == ST_FILL) begin
			we = 1'b1;
			wdata = 16'd0;
		end else if (state_q == ST_CLEAR) begin
			we = 1'b1;
			wdata = BLANK_CELL;
		end
		if (take) raddr = op.pos;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cursor_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			scr_q <= 1'b0;
			rdout_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						scr_q <= 1'b0;
						rdout_q <= '0;
						state_q <= ST_DONE;
						case (op.op)
							OP_WRITE, OP_NEWLINE: begin
								if ((op.op == OP_NEWLINE ? nl_where : where)
										== CW'(CELLS - 1)) begin
									idx_q <= '0;
									state_q <= ST_SCR_RD;
								end else begin
									cursor_q <= (op.op == OP_NEWLINE ? nl_where : where) + 1'b1;
								end
							end
							OP_MOVE: begin
								if (moved < 0) cursor_q <= '0;
								else if (moved > (CW+2)'(CELLS - 1)) cursor_q <= CW'(CELLS - 1);
								else cursor_q <= moved[CW-1:0];
							end
							OP_CLEAR: begin
								idx_q <= '0;
								state_q <= ST_CLEAR;
							end
							OP_READ: state_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_READ: begin
					rdout_q <= rd_q;
					state_q <= ST_DONE;
				end
				// Copy each cell of rows 1..last to the row above: read, then write.
				ST_SCR_RD: state_q <= ST_SCR_WR;
				ST_SCR_WR: begin
					if (idx_q == CW'(CELLS - COLUMNS - 1)) begin
						state_q <= ST_FILL;
					end else begin
						state_q <= ST_SCR_RD;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_FILL: begin
					if (idx_q == CW'(CELLS - 1)) begin
						cursor_q <= CW'(CELLS - COLUMNS);
						scr_q <= 1'b1;
						state_q <= ST_DONE;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_CLEAR: begin
					if (idx_q == CW'(CELLS - 1)) begin
						cursor_q <= '0;
						state_q <= ST_DONE;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_DONE: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`include "text_console_writer_top_macros.svh"
	`TCW_ASSERT(a_cursor_range, cursor_q <= CW'(CELLS - 1), "cursor out of range")
	`TCW_ASSERT(a_no_take_busy, !(take && out_valid_q), "took an op while a result waits")
	`TCW_ASSERT_NEXT(a_done_out, state_q == ST_DONE, out_valid_q, "result not raised")
endmodule
`default_nettype wire

// ===== test/tb.sv =====
//------------------------------------------------------------------------------
// Console writer testbench
// Drives character, position, move, clear, read and undefined commands into the console
// writer. A behavioral screen model predicts the cursor, the scroll flag and
// the cell read back for every command. Random input gaps and output stalls are
// applied, and the default attribute register is changed between phases.
//------------------------------------------------------------------------------
`default_nettype none
module tb;
	import tcw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 4200;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [10:0] cursor;
		logic scr;
		logic [7:0] rd_char;
		logic [7:0] rd_attr;
	} console_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] command = CMD_PUT_CUR;
	logic [7:0] character = '0;
	logic [7:0] attribute = '0;
	logic [6:0] column = '0;
	logic [4:0] row = '0;
	logic signed [11:0] delta = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [10:0] cursor_cell;
	logic scrolled;
	logic [7:0] read_character;
	logic [7:0] read_attribute;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	text_console_writer_top dut (.*);

	always #6 clk = ~clk;

	// Screen model state.
	logic [15:0] screen [CELLS];
	int cursor_pos;
	logic [7:0] dflt_attr;

	console_result_t expected_results [$];
	int errors = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int idle_count = 0;

	function automatic int clamp_cell(logic [6:0] col, logic [4:0] rw);
		int c, r;
		c = (col > COLUMNS - 1) ? COLUMNS - 1 : int'(col);
		r = (rw > ROWS - 1) ? ROWS - 1 : int'(rw);
		return r * COLUMNS + c;
	endfunction

	// Writes one character, or handles a newline, and advances the cursor; returns 1 on a scroll.
	function automatic logic place_char(int where, logic [7:0] ch, logic [7:0] at);
		if (ch == NEWLINE) begin
			where = (where / COLUMNS) * COLUMNS + COLUMNS - 1;
		end else begin
			screen[where] = {(at == 8'd0) ? dflt_attr : at, ch};
		end
		if (where + 1 >= CELLS) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				screen[i] = screen[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen[i] = 16'h0000;
			cursor_pos = CELLS - COLUMNS;
			return 1'b1;
		end
		cursor_pos = where + 1;
		return 1'b0;
	endfunction

	function automatic console_result_t console_predict(logic [2:0] cmd, logic [7:0] ch,
			logic [7:0] at, logic [6:0] col, logic [4:0] rw, logic signed [11:0] dl);
		console_result_t r;
		int moved;
		r.scr = 1'b0;
		r.rd_char = '0;
		r.rd_attr = '0;
		case (cmd)
			CMD_PUT_CUR: if (ch != 8'd0) r.scr = place_char(cursor_pos, ch, at);
			CMD_PUT_POS: if (ch != 8'd0) r.scr = place_char(clamp_cell(col, rw), ch, at);
			CMD_MOVE: begin
				moved = cursor_pos + int'(dl);
				if (moved < 0) moved = 0;
				if (moved > CELLS - 1) moved = CELLS - 1;
				cursor_pos = moved;
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = BLANK_CELL;
				cursor_pos = 0;
			end
			CMD_READ: {r.rd_attr, r.rd_char} = screen[clamp_cell(col, rw)];
			default: ;
		endcase
		r.cursor = cursor_pos[10:0];
		return r;
	endfunction

	// Leaves in_valid high after the beat; wait_drain, or a random gap in the next call, lowers it.
	task automatic send_command(logic [2:0] cmd, logic [7:0] ch, logic [7:0] at,
			logic [6:0] col, logic [4:0] rw, logic signed [11:0] dl);
		if (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		character <= ch;
		attribute <= at;
		column <= col;
		row <= rw;
		delta <= dl;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(console_predict(cmd, ch, at, col, rw, dl));
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_default_attr(logic [7:0] value);
		wait_drain();
		// A scroll or clear is finished before its result beat, so none is running here.
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 2'd0;
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		dflt_attr = value;
	endtask

	// Result checker.
	always @(posedge clk) begin
		console_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat cursor=%0d", $time, cursor_cell);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (cursor_cell !== e.cursor) begin
					$display("%0t: cursor_cell expected %0d actual %0d", $time, e.cursor,
						cursor_cell);
					errors++;
				end
				if (scrolled !== e.scr) begin
					$display("%0t: scrolled expected %0d actual %0d", $time, e.scr, scrolled);
					errors++;
				end
				if (read_character !== e.rd_char) begin
					$display("%0t: read_character expected %0h actual %0h", $time, e.rd_char,
						read_character);
					errors++;
				end
				if (read_attribute !== e.rd_attr) begin
					$display("%0t: read_attribute expected %0h actual %0h", $time, e.rd_attr,
						read_attribute);
					errors++;
				end
			end
		end
	end

	// Receiver stalls, with one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 17);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_puts_default();
		send_command(CMD_PUT_CUR, 8'h41, 8'h00, 7'd0, 5'd0, 12'sd0);
		send_command(CMD_PUT_CUR, 8'hFF, 8'hFF, 7'd0, 5'd0, 12'sd0);
		send_command(CMD_PUT_CUR, 8'h00, 8'h12, 7'd0, 5'd0, 12'sd0);
		send_command(CMD_PUT_CUR, NEWLINE, 8'h00, 7'd0, 5'd0, 12'sd0);
		send_command(CMD_PUT_POS, 8'h01, 8'h80, 7'd5, 5'd2, 12'sd0);
		send_command(CMD_READ, 8'h00, 8'h00, 7'd5, 5'd2, 12'sd0);
		// Last cell saturated from out-of-range column and row scrolls the screen.
		send_command(CMD_PUT_POS, 8'h7E, 8'h01, 7'd127, 5'd31, 12'sd0);
		send_command(CMD_PUT_POS, NEWLINE, 8'h00, 7'd3, 5'd24, 12'sd0);
	endtask

	task automatic test_moves();
		send_command(CMD_MOVE, 8'h00, 8'h00, 7'd0, 5'd0, 12'sd2047);
		send_command(CMD_PUT_CUR, 8'h5A, 8'h07, 7'd0, 5'd0, 12'sd0);
		send_command(CMD_MOVE, 8'h00, 8'h00, 7'd0, 5'd0, -12'sd2048);
		send_command(CMD_MOVE, 8'h00, 8'h00, 7'd0, 5'd0, 12'sd2000);
		send_command(CMD_MOVE, 8'h00, 8'h00, 7'd0, 5'd0, -12'sd2000);
		send_command(CMD_MOVE, 8'h00, 8'h00, 7'd0, 5'd0, 12'sd0);
	endtask

	task automatic test_clear_read();
		send_command(CMD_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0, 12'sd0);
		send_command(CMD_READ, 8'h00, 8'h00, 7'd0, 5'd0, 12'sd0);
		send_command(CMD_READ, 8'h00, 8'h00, 7'd127, 5'd31, 12'sd0);
		send_command(CMD_READ, 8'h00, 8'h00, 7'd90, 5'd1, 12'sd0);
		send_command(CMD_READ, 8'h00, 8'h00, 7'd2, 5'd30, 12'sd0);
		for (logic [2:0] c = 3'd5; c != 3'd0; c++)
			send_command(c, 8'h33, 8'h00, 7'd1, 5'd1, 12'sd1);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++)
			send_command(CMD_PUT_CUR, 8'($urandom_range(255, 11)), 8'($urandom), 7'd0, 5'd0,
				12'sd0);
		wait_drain();
	endtask

	task automatic test_random(int count);
		logic [6:0] col;
		logic [4:0] rw;
		int pick;
		for (int i = 0; i < count; i++) begin
			calm = (i < 100);
			col = ($urandom_range(99) < 20) ? 7'($urandom) : 7'($urandom_range(78));
			rw = ($urandom_range(99) < 15) ? 5'($urandom) : 5'($urandom_range(23));
			pick = $urandom_range(99);
			if (pick < 40)
				send_command(CMD_PUT_CUR, ($urandom_range(9) == 0) ? NEWLINE : 8'($urandom),
					($urandom_range(3) == 0) ? 8'h00 : 8'($urandom), col, rw, 12'($urandom));
			else if (pick < 60)
				send_command(CMD_PUT_POS, 8'($urandom), 8'($urandom), col, rw, 12'($urandom));
			else if (pick < 75)
				send_command(CMD_MOVE, 8'($urandom), 8'($urandom), col, rw, 12'($urandom));
			else if (pick < 93)
				send_command(CMD_READ, 8'($urandom), 8'($urandom), col, rw, 12'($urandom));
			else if (pick < 96)
				send_command(CMD_CLEAR, 8'($urandom), 8'($urandom), col, rw, 12'($urandom));
			else
				send_command(3'($urandom_range(7, 5)), 8'($urandom), 8'($urandom), col, rw,
					12'($urandom));
		end
		calm = 1'b0;
	endtask

	initial begin
		cursor_pos = 0;
		dflt_attr = 8'd15;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_puts_default();
		test_moves();
		test_clear_read();
		test_backpressure();
		write_default_attr(8'd0);
		test_random(200);
		write_default_attr(8'd255);
		test_random(200);
		write_default_attr(8'($urandom));
		test_random(200);
		write_default_attr(8'd15);
		test_random(80);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
